/* rtl/core/gtl_pkg.sv */
// ----------------------------------------------------------------------------
// gtl_pkg
// Shared constants, result kinds and the issue record for the glyph to
// lcd pixel row generator.
// ----------------------------------------------------------------------------
package gtl_pkg;

    // font geometry
    localparam int GLYPH_HEIGHT = 12;
    localparam int GLYPH_COUNT  = 95;
    localparam int GLYPH_W      = GLYPH_HEIGHT / 2;
    localparam int ROM_GLYPHS   = 95;
    localparam int ROM_ROWS     = 12;
    localparam int ROM_BITS     = 6;
    localparam int PIX_FIELDS   = 6;

    // glyphs actually reachable from a character code
    localparam int GLYPH_USE = (GLYPH_COUNT < ROM_GLYPHS) ? GLYPH_COUNT : ROM_GLYPHS;
    localparam int GIDX_W    = (GLYPH_USE > 1) ? $clog2(GLYPH_USE) : 1;
    localparam int ROW_W     = $clog2(GLYPH_HEIGHT);

    // results per character: two windows and a write command, then the pixel rows
    localparam int HDR_PHASES = 3;
    localparam int NUM_RES    = HDR_PHASES + GLYPH_HEIGHT;
    localparam int PHASE_W    = $clog2(NUM_RES);
    localparam int LAST_PHASE = NUM_RES - 1;

    localparam logic [7:0] CODE_FIRST = 8'd32;

    // panel command bytes
    localparam logic [7:0] CMD_COLUMN = 8'h2a;
    localparam logic [7:0] CMD_ROW    = 8'h2b;
    localparam logic [7:0] CMD_WRITE  = 8'h2c;
    localparam logic [7:0] CMD_NONE   = 8'h00;

    // configuration register indexes
    localparam logic CFG_COLUMN_OFFSET = 1'b0;
    localparam logic CFG_ROW_OFFSET    = 1'b1;

    localparam logic [7:0] COLUMN_OFFSET_RST = 8'd40;
    localparam logic [7:0] ROW_OFFSET_RST    = 8'd52;

    typedef enum logic [1:0] {
        KIND_COLUMN = 2'd0,
        KIND_ROW    = 2'd1,
        KIND_WRITE  = 2'd2,
        KIND_PIXEL  = 2'd3
    } t_kind;

    // one result as it leaves the sequencer, before the font data joins it
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  command;
        logic [15:0] wstart;
        logic [15:0] wend;
        logic [15:0] fg;
        logic [15:0] bg;
        logic        last;
    } t_issue;

endpackage

/* rtl/core/gtl_font_rom.sv */
// ----------------------------------------------------------------------------
// gtl_font_rom
// Synchronous 6x12 glyph memory, one registered row read per enabled cycle.
// ----------------------------------------------------------------------------
module gtl_font_rom (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [gtl_pkg::GIDX_W-1:0] i_glyph,
    input  logic [gtl_pkg::ROW_W-1:0]  i_row,
    output logic [gtl_pkg::ROM_BITS-1:0] o_bits
);

    localparam int ROM_ROW_W = $clog2(gtl_pkg::ROM_ROWS);

    localparam logic [gtl_pkg::ROM_BITS-1:0]
        FONT_ROM [gtl_pkg::ROM_GLYPHS][gtl_pkg::ROM_ROWS] = '{
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00},
        '{6'h00,6'h00,6'h04,6'h04,6'h04,6'h04,6'h04,6'h00,6'h00,6'h04,6'h00,6'h00},
        '{6'h14,6'h14,6'h0A,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00},
        '{6'h00,6'h00,6'h0A,6'h0A,6'h1F,6'h0A,6'h0A,6'h1F,6'h0A,6'h0A,6'h00,6'h00},
        '{6'h00,6'h04,6'h0E,6'h15,6'h05,6'h06,6'h0C,6'h14,6'h15,6'h0E,6'h04,6'h00},
        '{6'h00,6'h00,6'h12,6'h15,6'h0D,6'h15,6'h2E,6'h2C,6'h2A,6'h12,6'h00,6'h00},
        '{6'h00,6'h00,6'h04,6'h0A,6'h0A,6'h36,6'h15,6'h15,6'h29,6'h16,6'h00,6'h00},
        '{6'h02,6'h02,6'h01,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00},
        '{6'h10,6'h08,6'h08,6'h04,6'h04,6'h04,6'h04,6'h04,6'h08,6'h08,6'h10,6'h00},
        '{6'h02,6'h04,6'h04,6'h08,6'h08,6'h08,6'h08,6'h08,6'h04,6'h04,6'h02,6'h00},
        '{6'h00,6'h00,6'h00,6'h04,6'h15,6'h0E,6'h0E,6'h15,6'h04,6'h00,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h08,6'h08,6'h3E,6'h08,6'h08,6'h00,6'h00,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h02,6'h02,6'h01,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h3F,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h02,6'h00,6'h00},
        '{6'h00,6'h20,6'h10,6'h10,6'h08,6'h08,6'h04,6'h04,6'h02,6'h02,6'h01,6'h00},
        '{6'h00,6'h00,6'h0E,6'h11,6'h11,6'h11,6'h11,6'h11,6'h11,6'h0E,6'h00,6'h00},
        '{6'h00,6'h00,6'h04,6'h06,6'h04,6'h04,6'h04,6'h04,6'h04,6'h0E,6'h00,6'h00},
        '{6'h00,6'h00,6'h0E,6'h11,6'h11,6'h08,6'h04,6'h02,6'h01,6'h1F,6'h00,6'h00},
        '{6'h00,6'h00,6'h0E,6'h11,6'h10,6'h0C,6'h10,6'h10,6'h11,6'h0E,6'h00,6'h00},
        '{6'h00,6'h00,6'h08,6'h0C,6'h0C,6'h0A,6'h09,6'h1F,6'h08,6'h1C,6'h00,6'h00},
        '{6'h00,6'h00,6'h1F,6'h01,6'h01,6'h0F,6'h11,6'h10,6'h11,6'h0E,6'h00,6'h00},
        '{6'h00,6'h00,6'h0C,6'h12,6'h01,6'h0D,6'h13,6'h11,6'h11,6'h0E,6'h00,6'h00},
        '{6'h00,6'h00,6'h1E,6'h10,6'h08,6'h08,6'h04,6'h04,6'h04,6'h04,6'h00,6'h00},
        '{6'h00,6'h00,6'h0E,6'h11,6'h11,6'h0E,6'h11,6'h11,6'h11,6'h0E,6'h00,6'h00},
        '{6'h00,6'h00,6'h0E,6'h11,6'h11,6'h19,6'h16,6'h10,6'h09,6'h06,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h04,6'h00,6'h00,6'h00,6'h00,6'h04,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h04,6'h00,6'h00,6'h00,6'h04,6'h04,6'h00},
        '{6'h00,6'h00,6'h10,6'h08,6'h04,6'h02,6'h02,6'h04,6'h08,6'h10,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h3F,6'h00,6'h3F,6'h00,6'h00,6'h00,6'h00,6'h00},
        '{6'h00,6'h00,6'h02,6'h04,6'h08,6'h10,6'h10,6'h08,6'h04,6'h02,6'h00,6'h00},
        '{6'h00,6'h00,6'h0E,6'h11,6'h11,6'h08,6'h04,6'h04,6'h00,6'h04,6'h00,6'h00},
        '{6'h00,6'h00,6'h1C,6'h22,6'h29,6'h2D,6'h2D,6'h1D,6'h22,6'h1C,6'h00,6'h00},
        '{6'h00,6'h00,6'h04,6'h04,6'h0C,6'h0A,6'h0A,6'h1E,6'h12,6'h33,6'h00,6'h00},
        '{6'h00,6'h00,6'h0F,6'h12,6'h12,6'h0E,6'h12,6'h12,6'h12,6'h0F,6'h00,6'h00},
        '{6'h00,6'h00,6'h1E,6'h11,6'h01,6'h01,6'h01,6'h01,6'h11,6'h0E,6'h00,6'h00},
        '{6'h00,6'h00,6'h0F,6'h12,6'h12,6'h12,6'h12,6'h12,6'h12,6'h0F,6'h00,6'h00},
        '{6'h00,6'h00,6'h1F,6'h12,6'h0A,6'h0E,6'h0A,6'h02,6'h12,6'h1F,6'h00,6'h00},
        '{6'h00,6'h00,6'h1F,6'h12,6'h0A,6'h0E,6'h0A,6'h02,6'h02,6'h07,6'h00,6'h00},
        '{6'h00,6'h00,6'h1C,6'h12,6'h01,6'h01,6'h39,6'h11,6'h12,6'h0C,6'h00,6'h00},
        '{6'h00,6'h00,6'h33,6'h12,6'h12,6'h1E,6'h12,6'h12,6'h12,6'h33,6'h00,6'h00},
        '{6'h00,6'h00,6'h1F,6'h04,6'h04,6'h04,6'h04,6'h04,6'h04,6'h1F,6'h00,6'h00},
        '{6'h00,6'h00,6'h3E,6'h08,6'h08,6'h08,6'h08,6'h08,6'h08,6'h08,6'h09,6'h07},
        '{6'h00,6'h00,6'h37,6'h12,6'h0A,6'h06,6'h0A,6'h12,6'h12,6'h37,6'h00,6'h00},
        '{6'h00,6'h00,6'h07,6'h02,6'h02,6'h02,6'h02,6'h02,6'h22,6'h3F,6'h00,6'h00},
        '{6'h00,6'h00,6'h3B,6'h1B,6'h1B,6'h1B,6'h15,6'h15,6'h15,6'h35,6'h00,6'h00},
        '{6'h00,6'h00,6'h3B,6'h12,6'h16,6'h16,6'h1A,6'h1A,6'h12,6'h17,6'h00,6'h00},
        '{6'h00,6'h00,6'h0E,6'h11,6'h11,6'h11,6'h11,6'h11,6'h11,6'h0E,6'h00,6'h00},
        '{6'h00,6'h00,6'h0F,6'h12,6'h12,6'h0E,6'h02,6'h02,6'h02,6'h07,6'h00,6'h00},
        '{6'h00,6'h00,6'h0E,6'h11,6'h11,6'h11,6'h11,6'h17,6'h19,6'h0E,6'h18,6'h00},
        '{6'h00,6'h00,6'h0F,6'h12,6'h12,6'h0E,6'h0A,6'h12,6'h12,6'h37,6'h00,6'h00},
        '{6'h00,6'h00,6'h1E,6'h11,6'h01,6'h06,6'h08,6'h10,6'h11,6'h0F,6'h00,6'h00},
        '{6'h00,6'h00,6'h1F,6'h15,6'h04,6'h04,6'h04,6'h04,6'h04,6'h0E,6'h00,6'h00},
        '{6'h00,6'h00,6'h33,6'h12,6'h12,6'h12,6'h12,6'h12,6'h12,6'h0C,6'h00,6'h00},
        '{6'h00,6'h00,6'h33,6'h12,6'h12,6'h0A,6'h0A,6'h0C,6'h04,6'h04,6'h00,6'h00},
        '{6'h00,6'h00,6'h15,6'h15,6'h15,6'h15,6'h0E,6'h0A,6'h0A,6'h0A,6'h00,6'h00},
        '{6'h00,6'h00,6'h1B,6'h0A,6'h0A,6'h04,6'h04,6'h0A,6'h0A,6'h1B,6'h00,6'h00},
        '{6'h00,6'h00,6'h1B,6'h0A,6'h0A,6'h0A,6'h04,6'h04,6'h04,6'h0E,6'h00,6'h00},
        '{6'h00,6'h00,6'h1F,6'h09,6'h08,6'h04,6'h04,6'h02,6'h12,6'h1F,6'h00,6'h00},
        '{6'h1C,6'h04,6'h04,6'h04,6'h04,6'h04,6'h04,6'h04,6'h04,6'h04,6'h1C,6'h00},
        '{6'h00,6'h02,6'h02,6'h04,6'h04,6'h04,6'h08,6'h08,6'h08,6'h10,6'h10,6'h00},
        '{6'h0E,6'h08,6'h08,6'h08,6'h08,6'h08,6'h08,6'h08,6'h08,6'h08,6'h0E,6'h00},
        '{6'h04,6'h0A,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h3F},
        '{6'h02,6'h04,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h0C,6'h12,6'h1C,6'h12,6'h3C,6'h00,6'h00},
        '{6'h00,6'h03,6'h02,6'h02,6'h02,6'h0E,6'h12,6'h12,6'h12,6'h0E,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h1C,6'h12,6'h02,6'h12,6'h0C,6'h00,6'h00},
        '{6'h00,6'h18,6'h10,6'h10,6'h10,6'h1C,6'h12,6'h12,6'h12,6'h3C,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h0C,6'h12,6'h1E,6'h02,6'h1C,6'h00,6'h00},
        '{6'h00,6'h18,6'h24,6'h04,6'h04,6'h1E,6'h04,6'h04,6'h04,6'h1E,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h3C,6'h12,6'h0C,6'h02,6'h1C,6'h22,6'h1C},
        '{6'h00,6'h03,6'h02,6'h02,6'h02,6'h0E,6'h12,6'h12,6'h12,6'h37,6'h00,6'h00},
        '{6'h00,6'h04,6'h04,6'h00,6'h00,6'h06,6'h04,6'h04,6'h04,6'h0E,6'h00,6'h00},
        '{6'h00,6'h08,6'h08,6'h00,6'h00,6'h0C,6'h08,6'h08,6'h08,6'h08,6'h08,6'h07},
        '{6'h00,6'h03,6'h02,6'h02,6'h02,6'h1A,6'h0A,6'h06,6'h0A,6'h13,6'h00,6'h00},
        '{6'h00,6'h07,6'h04,6'h04,6'h04,6'h04,6'h04,6'h04,6'h04,6'h1F,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h0F,6'h15,6'h15,6'h15,6'h15,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h0F,6'h12,6'h12,6'h12,6'h37,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h0C,6'h12,6'h12,6'h12,6'h0C,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h0F,6'h12,6'h12,6'h12,6'h0E,6'h02,6'h07},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h1C,6'h12,6'h12,6'h12,6'h1C,6'h10,6'h38},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h1B,6'h06,6'h02,6'h02,6'h07,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h1E,6'h02,6'h0C,6'h10,6'h1E,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h04,6'h04,6'h1E,6'h04,6'h04,6'h04,6'h1C,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h1B,6'h12,6'h12,6'h12,6'h3C,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h1B,6'h0A,6'h0A,6'h04,6'h04,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h15,6'h15,6'h0E,6'h0A,6'h0A,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h1B,6'h0A,6'h04,6'h0A,6'h1B,6'h00,6'h00},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h33,6'h12,6'h12,6'h0C,6'h08,6'h04,6'h03},
        '{6'h00,6'h00,6'h00,6'h00,6'h00,6'h1E,6'h08,6'h04,6'h04,6'h1E,6'h00,6'h00},
        '{6'h18,6'h08,6'h08,6'h08,6'h08,6'h0C,6'h08,6'h08,6'h08,6'h08,6'h18,6'h00},
        '{6'h08,6'h08,6'h08,6'h08,6'h08,6'h08,6'h08,6'h08,6'h08,6'h08,6'h08,6'h08},
        '{6'h06,6'h04,6'h04,6'h04,6'h04,6'h08,6'h04,6'h04,6'h04,6'h04,6'h06,6'h00},
        '{6'h16,6'h09,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00}
    };

    logic [gtl_pkg::ROM_BITS-1:0] r_bits;

    // registered read, rows below the stored glyph read as blank
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (int'(i_row) < gtl_pkg::ROM_ROWS) begin
                r_bits <= FONT_ROM[i_glyph][ROM_ROW_W'(i_row)];
            end else begin
                r_bits <= '0;
            end
        end
    end

    assign o_bits = r_bits;

endmodule

/* rtl/core/gtl_seq.sv */
// ----------------------------------------------------------------------------
// gtl_seq
// Character sequencer: takes a character, keeps the cursor and steps through
// the window and write results and glyph rows, one result per advance.
// ----------------------------------------------------------------------------
module gtl_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_char_code,
    input  logic                         i_new_string,
    input  logic [15:0]                  i_start_x,
    input  logic [15:0]                  i_start_y,
    input  logic [15:0]                  i_fore_color,
    input  logic [15:0]                  i_back_color,
    input  logic [7:0]                   i_column_offset,
    input  logic [7:0]                   i_row_offset,
    input  logic                         i_adv,
    output logic                         o_issue_valid,
    output gtl_pkg::t_issue              o_issue,
    output logic [gtl_pkg::GIDX_W-1:0]   o_glyph,
    output logic [gtl_pkg::ROW_W-1:0]    o_row
);

    localparam logic [gtl_pkg::PHASE_W-1:0] LAST_PH =
        gtl_pkg::PHASE_W'(gtl_pkg::LAST_PHASE);
    localparam logic [gtl_pkg::PHASE_W-1:0] HDR_PH =
        gtl_pkg::PHASE_W'(gtl_pkg::HDR_PHASES);

    logic                          r_busy;
    logic [gtl_pkg::PHASE_W-1:0]   r_phase;
    logic [15:0]                   r_cursor;
    logic [gtl_pkg::GIDX_W-1:0]    r_glyph;
    logic [15:0]                   r_x;
    logic [15:0]                   r_y;
    logic [15:0]                   r_fg;
    logic [15:0]                   r_bg;

    logic                          w_last;
    logic                          w_take;
    logic [15:0]                   n_x;
    logic [7:0]                    w_code_off;
    logic                          w_in_font;
    logic [gtl_pkg::GIDX_W-1:0]    n_glyph;
    logic [gtl_pkg::PHASE_W-1:0]   w_row_full;

    assign w_last     = (r_phase == LAST_PH);
    assign o_in_ready = !r_busy || (i_adv && w_last);
    assign w_take     = i_in_valid && o_in_ready;

    // glyph select, codes outside the font fall back to space
    assign w_code_off = i_char_code - gtl_pkg::CODE_FIRST;
    assign w_in_font  = (i_char_code >= gtl_pkg::CODE_FIRST) &&
                        ({1'b0, w_code_off} < 9'(gtl_pkg::GLYPH_USE));
    assign n_glyph    = w_in_font ? w_code_off[gtl_pkg::GIDX_W-1:0] : '0;
    assign n_x        = i_new_string ? i_start_x : r_cursor;

    // control and cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= '0;
            r_cursor <= '0;
        end else if (w_take) begin
            r_busy   <= 1'b1;
            r_phase  <= '0;
            r_cursor <= n_x + 16'(gtl_pkg::GLYPH_W);
        end else if (i_adv && r_busy) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_phase <= r_phase + 1'b1;
            end
        end
    end

    // character payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_glyph <= n_glyph;
            r_x     <= n_x;
            r_y     <= i_start_y;
            r_fg    <= i_fore_color;
            r_bg    <= i_back_color;
        end
    end

    // font address for the current glyph row
    assign w_row_full = r_phase - HDR_PH;
    assign o_row      = w_row_full[gtl_pkg::ROW_W-1:0];
    assign o_glyph    = r_glyph;

    // result for the current phase
    always_comb begin
        o_issue         = '0;
        o_issue.fg      = r_fg;
        o_issue.bg      = r_bg;
        o_issue.last    = w_last;
        case (r_phase)
            gtl_pkg::PHASE_W'(0): begin
                o_issue.kind    = gtl_pkg::KIND_COLUMN;
                o_issue.command = gtl_pkg::CMD_COLUMN;
                o_issue.wstart  = r_x + {8'd0, i_column_offset};
                o_issue.wend    = (r_x + 16'(gtl_pkg::GLYPH_W - 1)) + {8'd0, i_column_offset};
            end
            gtl_pkg::PHASE_W'(1): begin
                o_issue.kind    = gtl_pkg::KIND_ROW;
                o_issue.command = gtl_pkg::CMD_ROW;
                o_issue.wstart  = r_y + {8'd0, i_row_offset};
                o_issue.wend    = (r_y + 16'(gtl_pkg::GLYPH_HEIGHT - 1)) + {8'd0, i_row_offset};
            end
            gtl_pkg::PHASE_W'(2): begin
                o_issue.kind    = gtl_pkg::KIND_WRITE;
                o_issue.command = gtl_pkg::CMD_WRITE;
            end
            default: begin
                o_issue.kind    = gtl_pkg::KIND_PIXEL;
                o_issue.command = gtl_pkg::CMD_NONE;
            end
        endcase
    end

    assign o_issue_valid = r_busy;

endmodule

/* rtl/core/gtl_out.sv */
// ----------------------------------------------------------------------------
// gtl_out
// Result register: holds one result until transfer and expands the glyph row
// into pixel colors.
// ----------------------------------------------------------------------------
module gtl_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_issue_valid,
    input  gtl_pkg::t_issue              i_issue,
    input  logic [gtl_pkg::ROM_BITS-1:0] i_bits,
    output logic                         o_adv,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_kind,
    output logic [7:0]                   o_command,
    output logic [15:0]                  o_window_start,
    output logic [15:0]                  o_window_end,
    output logic [15:0]                  o_pixel_a,
    output logic [15:0]                  o_pixel_b,
    output logic [15:0]                  o_pixel_c,
    output logic [15:0]                  o_pixel_d,
    output logic [15:0]                  o_pixel_e,
    output logic [15:0]                  o_pixel_f,
    output logic                         o_last_of_char
);

    logic            r_valid;
    gtl_pkg::t_issue r_issue;
    logic [15:0]     w_pix [gtl_pkg::PIX_FIELDS];

    // register is free when empty or being drained this cycle
    assign o_adv = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_issue_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_issue <= i_issue;
        end
    end

    // glyph bit p picks the color of pixel p, leftmost first
    always_comb begin
        for (int p = 0; p < gtl_pkg::PIX_FIELDS; p++) begin
            if (p < gtl_pkg::GLYPH_W && r_issue.kind == gtl_pkg::KIND_PIXEL) begin
                w_pix[p] = i_bits[p] ? r_issue.fg : r_issue.bg;
            end else begin
                w_pix[p] = '0;
            end
        end
    end

    assign o_out_valid    = r_valid;
    assign o_kind         = r_issue.kind;
    assign o_command      = r_issue.command;
    assign o_window_start = r_issue.wstart;
    assign o_window_end   = r_issue.wend;
    assign o_pixel_a      = w_pix[0];
    assign o_pixel_b      = w_pix[1];
    assign o_pixel_c      = w_pix[2];
    assign o_pixel_d      = w_pix[3];
    assign o_pixel_e      = w_pix[4];
    assign o_pixel_f      = w_pix[5];
    assign o_last_of_char = r_issue.last && (r_issue.kind == gtl_pkg::KIND_PIXEL);

endmodule

/* rtl/core/glyph_to_lcd_pixel_rows_top.sv */
// ----------------------------------------------------------------------------
// glyph_to_lcd_pixel_rows_top
// Bitmap font character generator: per character, column and row window
// commands, a memory write command and twelve rows of six RGB565 pixels.
// ----------------------------------------------------------------------------
// The input transfer loads the sequencer, and its first result then enters
// the result register. 15 results per character at one per cycle while the
// output is not stalled; the sequencer and its single font read port set it.
// Back-pressure on the result side stalls the sequencer and font read alike.
// Reset (i_rst_n low, synchronous): cursor to zero, offsets to 40 and 52,
// sequencer and result register empty. No clearing pass; font is fixed.
module glyph_to_lcd_pixel_rows_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_new_string,
    input  logic [15:0] i_start_x,
    input  logic [15:0] i_start_y,
    input  logic [15:0] i_fore_color,
    input  logic [15:0] i_back_color,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_command,
    output logic [15:0] o_window_start,
    output logic [15:0] o_window_end,
    output logic [15:0] o_pixel_a,
    output logic [15:0] o_pixel_b,
    output logic [15:0] o_pixel_c,
    output logic [15:0] o_pixel_d,
    output logic [15:0] o_pixel_e,
    output logic [15:0] o_pixel_f,
    output logic        o_last_of_char,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0]                    r_column_offset;
    logic [7:0]                    r_row_offset;
    logic                          w_adv;
    logic                          w_issue_valid;
    gtl_pkg::t_issue               w_issue;
    logic [gtl_pkg::GIDX_W-1:0]    w_glyph;
    logic [gtl_pkg::ROW_W-1:0]     w_row;
    logic [gtl_pkg::ROM_BITS-1:0]  w_bits;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_offset <= gtl_pkg::COLUMN_OFFSET_RST;
            r_row_offset    <= gtl_pkg::ROW_OFFSET_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gtl_pkg::CFG_COLUMN_OFFSET: r_column_offset <= i_cfg_data;
                gtl_pkg::CFG_ROW_OFFSET:    r_row_offset    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    gtl_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_char_code     (i_char_code),
        .i_new_string    (i_new_string),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_fore_color    (i_fore_color),
        .i_back_color    (i_back_color),
        .i_column_offset (r_column_offset),
        .i_row_offset    (r_row_offset),
        .i_adv           (w_adv),
        .o_issue_valid   (w_issue_valid),
        .o_issue         (w_issue),
        .o_glyph         (w_glyph),
        .o_row           (w_row)
    );

    // font memory, read alongside the result register load
    gtl_font_rom u_rom (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_glyph (w_glyph),
        .i_row   (w_row),
        .o_bits  (w_bits)
    );

    // result register
    gtl_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_issue_valid  (w_issue_valid),
        .i_issue        (w_issue),
        .i_bits         (w_bits),
        .o_adv          (w_adv),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_command      (o_command),
        .o_window_start (o_window_start),
        .o_window_end   (o_window_end),
        .o_pixel_a      (o_pixel_a),
        .o_pixel_b      (o_pixel_b),
        .o_pixel_c      (o_pixel_c),
        .o_pixel_d      (o_pixel_d),
        .o_pixel_e      (o_pixel_e),
        .o_pixel_f      (o_pixel_f),
        .o_last_of_char (o_last_of_char)
    );

endmodule

/* rtl/core/gtl_checker.sv */
// ----------------------------------------------------------------------------
// gtl_checker
// Port-level checks on the character generator, attached to the top level.
// ----------------------------------------------------------------------------
module gtl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [15:0] o_window_start,
    input logic [15:0] o_window_end,
    input logic        o_last_of_char
);

    // a stalled result holds its kind and bounds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_kind) && $stable(o_window_start) &&
            $stable(o_window_end))
        else $error("result changed while stalled");

    // a column window transfer is followed at once by the row window
    a_col_then_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_kind == gtl_pkg::KIND_COLUMN |=>
            o_out_valid && o_kind == gtl_pkg::KIND_ROW)
        else $error("row window did not follow column window");

    // column window spans exactly the glyph width
    a_col_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == gtl_pkg::KIND_COLUMN |->
            o_window_end == o_window_start + 16'(gtl_pkg::GLYPH_W - 1))
        else $error("column window span wrong");

    // end of character marked only on a pixel row
    a_last_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_char |-> o_kind == gtl_pkg::KIND_PIXEL)
        else $error("end of character on a window result");

    // a character transfer keeps the input closed the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input reopened right after a transfer");

endmodule

bind glyph_to_lcd_pixel_rows_top gtl_checker u_gtl_checker (.*);
